[design/mep_pkg.sv]
package mep_pkg;

    // Image size defaults
    localparam int IMG_WIDTH_DEF  = 900;
    localparam int IMG_HEIGHT_DEF = 800;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd4;
    localparam int CFG_DATA_W = 32;

    // Register reset values
    localparam logic [30:0]        STEP_RE_RST   = 31'd894785;
    localparam logic [30:0]        STEP_IM_RST   = 31'd671089;
    localparam logic signed [31:0] CENTER_RE_RST = -32'sd134217728;
    localparam logic signed [31:0] CENTER_IM_RST = 32'sd0;
    localparam logic [9:0]         MAX_ITER_RST  = 10'd200;

    // Colour accumulator and escape arithmetic
    localparam logic [31:0] COLOR_RST  = 32'd9999;
    localparam logic [31:0] COLOR_STEP = 32'd250;
    localparam int          FRAC_BITS  = 28;
    localparam logic [63:0] ESC_LIMIT  = 64'h0400_0000_0000_0000;

    typedef struct packed {
        logic [9:0] pixel_x;
        logic [9:0] pixel_y;
    } t_in_item;

    typedef struct packed {
        logic [31:0] pixel_color;
        logic        drawn;
        logic [9:0]  rounds_done;
    } t_out_item;

    typedef struct packed {
        logic [30:0]        step_re;
        logic [30:0]        step_im;
        logic signed [31:0] center_re;
        logic signed [31:0] center_im;
        logic [9:0]         max_iter;
    } t_cfg;

    // Operand pairs for the three multipliers
    typedef struct packed {
        logic signed [31:0] a0;
        logic signed [31:0] b0;
        logic signed [31:0] a1;
        logic signed [31:0] b1;
        logic signed [31:0] a2;
        logic signed [31:0] b2;
    } t_mul_ops;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[design/mep_cmul.sv]
module mep_cmul (
    input  logic                i_clk,
    input  mep_pkg::t_mul_ops   i_ops,
    output logic signed [63:0]  o_p0,
    output logic signed [63:0]  o_p1,
    output logic signed [63:0]  o_p2
);

    logic signed [63:0] r_p0;
    logic signed [63:0] r_p1;
    logic signed [63:0] r_p2;

    // Multiply the three operand pairs, register each product
    always_ff @(posedge i_clk) begin
        r_p0 <= i_ops.a0 * i_ops.b0;
        r_p1 <= i_ops.a1 * i_ops.b1;
        r_p2 <= i_ops.a2 * i_ops.b2;
    end

    assign o_p0 = r_p0;
    assign o_p1 = r_p1;
    assign o_p2 = r_p2;

endmodule

[design/mep_seq.sv]
module mep_seq #(
    parameter int IMG_WIDTH  = mep_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = mep_pkg::IMG_HEIGHT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  mep_pkg::t_in_item  i_item,
    input  mep_pkg::t_cfg      i_cfg,
    input  logic               i_out_free,
    output logic               o_ready,
    output logic               o_done,
    output mep_pkg::t_out_item o_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAP  = 3'd1;
    localparam logic [2:0] S_CMAP = 3'd2;
    localparam logic [2:0] S_SQ   = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    localparam logic signed [31:0] HALF_W = 32'(IMG_WIDTH / 2);
    localparam logic signed [31:0] HALF_H = 32'(IMG_HEIGHT / 2);

    logic [2:0]         r_state, n_state;
    logic signed [31:0] r_ox, n_ox;
    logic signed [31:0] r_oy, n_oy;
    logic signed [31:0] r_cr, n_cr;
    logic signed [31:0] r_ci, n_ci;
    logic signed [31:0] r_zr, n_zr;
    logic signed [31:0] r_zi, n_zi;
    logic               r_chk, n_chk;
    logic [9:0]         r_rounds, n_rounds;
    logic [31:0]        r_acc, n_acc;

    mep_pkg::t_mul_ops  mul_ops;
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] re_sum;
    logic signed [63:0] im_sum;
    logic signed [31:0] nr;
    logic signed [31:0] ni;
    logic [63:0]        mag;
    logic [9:0]         rounds_inc;

    // Shared multiplier unit
    mep_cmul u_cmul (
        .i_clk (i_clk),
        .i_ops (mul_ops),
        .o_p0  (p0),
        .o_p1  (p1),
        .o_p2  (p2)
    );

    // Select operands: pixel offsets times steps, or the squares and the cross product of z
    always_comb begin
        if (r_state == S_MAP) begin
            mul_ops.a0 = r_ox;
            mul_ops.b0 = $signed({1'b0, i_cfg.step_re});
            mul_ops.a1 = r_oy;
            mul_ops.b1 = $signed({1'b0, i_cfg.step_im});
            mul_ops.a2 = '0;
            mul_ops.b2 = '0;
        end else begin
            mul_ops.a0 = r_zr;
            mul_ops.b0 = r_zr;
            mul_ops.a1 = r_zi;
            mul_ops.b1 = r_zi;
            mul_ops.a2 = r_zr;
            mul_ops.b2 = r_zi;
        end
    end

    // Form the next z from the registered products; arithmetic shift floors
    always_comb begin
        re_sum = ((p0 - p1) >>> mep_pkg::FRAC_BITS) + 64'(r_cr);
        im_sum = (p2 >>> (mep_pkg::FRAC_BITS - 1)) + 64'(r_ci);
        nr     = mep_pkg::sat32(re_sum);
        ni     = mep_pkg::sat32(im_sum);
        mag    = $unsigned(p0) + $unsigned(p1);
        rounds_inc = r_rounds + 10'd1;
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_cr     = r_cr;
        n_ci     = r_ci;
        n_zr     = r_zr;
        n_zi     = r_zi;
        n_chk    = r_chk;
        n_rounds = r_rounds;
        n_acc    = r_acc;
        o_done   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_ox     = $signed({22'd0, i_item.pixel_x}) - HALF_W;
                    n_oy     = $signed({22'd0, i_item.pixel_y}) - HALF_H;
                    n_rounds = '0;
                    n_state  = S_MAP;
                end
            end
            S_MAP: begin
                n_state = S_CMAP;
            end
            S_CMAP: begin
                n_cr  = mep_pkg::sat32(p0 + 64'(i_cfg.center_re));
                n_ci  = mep_pkg::sat32(p1 + 64'(i_cfg.center_im));
                n_zr  = '0;
                n_zi  = '0;
                n_chk = 1'b0;
                if (i_cfg.max_iter == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                n_state = S_UPD;
            end
            S_UPD: begin
                // Products hold the squares of the current z: test it first
                if (r_chk && (mag > mep_pkg::ESC_LIMIT)) begin
                    n_state = S_DONE;
                end else begin
                    if (r_chk) begin
                        n_acc    = r_acc + mep_pkg::COLOR_STEP;
                        n_rounds = rounds_inc;
                    end
                    if (r_chk && (rounds_inc == i_cfg.max_iter)) begin
                        n_state = S_DONE;
                    end else begin
                        n_zr    = nr;
                        n_zi    = ni;
                        n_chk   = 1'b1;
                        n_state = S_SQ;
                    end
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and the persistent accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_acc    <= mep_pkg::COLOR_RST;
            r_chk    <= 1'b0;
            r_rounds <= '0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_chk    <= n_chk;
            r_rounds <= n_rounds;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_ox <= n_ox;
        r_oy <= n_oy;
        r_cr <= n_cr;
        r_ci <= n_ci;
        r_zr <= n_zr;
        r_zi <= n_zi;
    end

    assign o_ready              = (r_state == S_IDLE);
    assign o_result.pixel_color = r_acc;
    assign o_result.drawn       = (r_rounds != '0);
    assign o_result.rounds_done = r_rounds;

    // Hand over an item only into a free output register
    a_done_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> i_out_free)
        else $error("result handed over while output register full");

    // Round count stays within the limit while a pixel is in work
    a_rounds_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_rounds <= i_cfg.max_iter))
        else $error("round count beyond max_iter");

    // Accumulator moves only in the update step
    a_acc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_UPD) |=> (r_acc == $past(r_acc)))
        else $error("accumulator changed outside update step");

endmodule

[design/mandelbrot_escape_pixel.sv]
// One pixel is in work at a time: a new item is accepted only after the last result has
// been handed to the output register, and a finished result waits while that register is
// full and stalled. Each z = z^2 + c round runs on the shared three-multiplier squaring unit.
// Reset (synchronous, active low): configuration, state and output-valid registers take their
// defaults, accumulator back to 9999.
module mandelbrot_escape_pixel #(
    parameter int IMG_WIDTH  = mep_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = mep_pkg::IMG_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mep_pkg::t_in_item                  i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mep_pkg::t_out_item                 o_out_item,
    input  logic                               i_cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    mep_pkg::t_cfg      r_cfg, n_cfg;
    logic               r_out_valid, n_out_valid;
    mep_pkg::t_out_item r_out_item;
    logic               seq_ready;
    logic               seq_done;
    logic               out_free;
    logic               in_accept;
    mep_pkg::t_out_item seq_result;

    assign in_accept = i_in_valid && seq_ready;
    assign out_free  = !r_out_valid || !i_out_stall;

    mep_seq #(
        .IMG_WIDTH  (IMG_WIDTH),
        .IMG_HEIGHT (IMG_HEIGHT)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_accept),
        .i_item     (i_in_item),
        .i_cfg      (r_cfg),
        .i_out_free (out_free),
        .o_ready    (seq_ready),
        .o_done     (seq_done),
        .o_result   (seq_result)
    );

    // Decode configuration writes; unknown indexes drop
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                mep_pkg::CFG_STEP_RE:   n_cfg.step_re   = i_cfg_data[30:0];
                mep_pkg::CFG_STEP_IM:   n_cfg.step_im   = i_cfg_data[30:0];
                mep_pkg::CFG_CENTER_RE: n_cfg.center_re = $signed(i_cfg_data);
                mep_pkg::CFG_CENTER_IM: n_cfg.center_im = $signed(i_cfg_data);
                mep_pkg::CFG_MAX_ITER:  n_cfg.max_iter  = i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Output valid: set on hand-over, clear when taken
    always_comb begin
        if (seq_done) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_re   <= mep_pkg::STEP_RE_RST;
            r_cfg.step_im   <= mep_pkg::STEP_IM_RST;
            r_cfg.center_re <= mep_pkg::CENTER_RE_RST;
            r_cfg.center_im <= mep_pkg::CENTER_IM_RST;
            r_cfg.max_iter  <= mep_pkg::MAX_ITER_RST;
            r_out_valid     <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    // Hold the result item until taken
    always_ff @(posedge i_clk) begin
        if (seq_done) begin
            r_out_item <= seq_result;
        end
    end

    assign o_in_stall  = !seq_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // An accepted item keeps the input stalled on the next cycle
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    // A hand-over always shows up as a valid output item
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_done |=> r_out_valid)
        else $error("result lost on hand-over");

    // No hand-over while a stalled item still waits
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !seq_done)
        else $error("output item overwritten while stalled");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam logic [mep_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [mep_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 750;
    localparam int HOLD_PHASE   = 4;
    localparam int HOLD_CYCLES  = 1500;

    // Escape-time predictor with its own copy of the view registers and the colour sum
    class escape_tracker;
        logic [30:0]        step_re;
        logic [30:0]        step_im;
        logic signed [31:0] centre_re;
        logic signed [31:0] centre_im;
        logic [9:0]         max_iter;
        logic [31:0]        colour_acc;
        mep_pkg::t_out_item expected_px[$];
        int                 mismatches;

        function new();
            step_re    = mep_pkg::STEP_RE_RST;
            step_im    = mep_pkg::STEP_IM_RST;
            centre_re  = mep_pkg::CENTER_RE_RST;
            centre_im  = mep_pkg::CENTER_IM_RST;
            max_iter   = mep_pkg::MAX_ITER_RST;
            colour_acc = mep_pkg::COLOR_RST;
            mismatches = 0;
        endfunction

        // Mirror one register write; unknown indexes change nothing
        function void set_reg(logic [mep_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                mep_pkg::CFG_STEP_RE:   step_re   = data[30:0];
                mep_pkg::CFG_STEP_IM:   step_im   = data[30:0];
                mep_pkg::CFG_CENTER_RE: centre_re = data;
                mep_pkg::CFG_CENTER_IM: centre_im = data;
                mep_pkg::CFG_MAX_ITER:  max_iter  = data[9:0];
                default: ;
            endcase
        endfunction

        // Clamp to the Q4.28 range
        function logic signed [31:0] clamp_q428(longint v);
            if (v > 64'sd2147483647) begin
                return 32'sh7FFF_FFFF;
            end
            if (v < -64'sd2147483648) begin
                return 32'sh8000_0000;
            end
            return v[31:0];
        endfunction

        // Map a pixel coordinate onto one axis of the complex plane
        function logic signed [31:0] axis_point(logic [9:0] coord, int dim,
                                                logic [30:0] step,
                                                logic signed [31:0] centre);
            longint off;
            off = longint'(coord) - longint'(dim / 2);
            return clamp_q428(off * longint'(step) + longint'(centre));
        endfunction

        // Iterate z = z^2 + c for an accepted pixel and queue the expected result
        function void note_coord(mep_pkg::t_in_item px);
            logic signed [31:0] cr, ci, zr, zi, nr, ni;
            longint             rr, ii, ri;
            logic [63:0]        mag;
            int unsigned        rounds;
            mep_pkg::t_out_item res;
            cr = axis_point(px.pixel_x, mep_pkg::IMG_WIDTH_DEF, step_re, centre_re);
            ci = axis_point(px.pixel_y, mep_pkg::IMG_HEIGHT_DEF, step_im, centre_im);
            zr = '0;
            zi = '0;
            rounds = 0;
            while (rounds < max_iter) begin
                rr = longint'(zr) * longint'(zr);
                ii = longint'(zi) * longint'(zi);
                ri = longint'(zr) * longint'(zi);
                nr = clamp_q428(((rr - ii) >>> mep_pkg::FRAC_BITS) + longint'(cr));
                ni = clamp_q428((ri >>> (mep_pkg::FRAC_BITS - 1)) + longint'(ci));
                mag = longint'(nr) * longint'(nr);
                mag = mag + longint'(ni) * longint'(ni);
                zr = nr;
                zi = ni;
                if (mag > mep_pkg::ESC_LIMIT) begin
                    break;
                end
                colour_acc += mep_pkg::COLOR_STEP;
                rounds++;
            end
            res.pixel_color = colour_acc;
            res.drawn       = (rounds != 0);
            res.rounds_done = rounds[9:0];
            expected_px.push_back(res);
        endfunction

        // Compare a delivered pixel with the oldest expectation
        function void check_px(mep_pkg::t_out_item got);
            mep_pkg::t_out_item want;
            if (expected_px.size() == 0) begin
                $display("%0t: pixel result with none expected: %p", $time, got);
                mismatches++;
                return;
            end
            want = expected_px.pop_front();
            if (got.pixel_color !== want.pixel_color) begin
                $display("%0t: pixel_color expected %0d got %0d",
                         $time, want.pixel_color, got.pixel_color);
                mismatches++;
            end
            if (got.drawn !== want.drawn) begin
                $display("%0t: drawn expected %0b got %0b", $time, want.drawn, got.drawn);
                mismatches++;
            end
            if (got.rounds_done !== want.rounds_done) begin
                $display("%0t: rounds_done expected %0d got %0d",
                         $time, want.rounds_done, got.rounds_done);
                mismatches++;
            end
        endfunction
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    mep_pkg::t_in_item              in_item   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    mep_pkg::t_out_item             out_item;
    logic                           cfg_we    = 1'b0;
    logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mep_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int            tx_gap_pct   = 0;
    int            rx_stall_pct = 0;
    bit            hold_req     = 1'b0;
    bit            hold_seen    = 1'b0;
    int            hold_left    = 0;
    int            cycles       = 0;
    escape_tracker tracker      = new();

    mandelbrot_escape_pixel dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    // Drive the result stall: a requested long hold first, random stalls otherwise
    always @(posedge clk) begin
        if (hold_req != hold_seen) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_req;
        end
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left--;
        end else begin
            out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Check results before noting new pixels; no result can follow its pixel this fast
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                tracker.check_px(out_item);
            end
            if (in_valid && !in_stall) begin
                tracker.note_coord(in_item);
            end
        end
    end

    // Select how often each side idles
    function void set_idling(int mode);
        case (mode)
            0: begin tx_gap_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_gap_pct = 65; rx_stall_pct = 0;  end
            2: begin tx_gap_pct = 0;  rx_stall_pct = 65; end
            default: begin tx_gap_pct = 27; rx_stall_pct = 27; end
        endcase
    endfunction

    // Offer one pixel, with optional idle cycles first, and hold it until taken
    task automatic send_xy(input int x, input int y);
        mep_pkg::t_in_item px;
        px.pixel_x = x[9:0];
        px.pixel_y = y[9:0];
        if ($urandom_range(99) < tx_gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < tx_gap_pct);
        end
        in_valid <= 1'b1;
        in_item  <= px;
        do @(posedge clk); while (in_stall);
    endtask

    // Drop valid and wait until every queued pixel has come back
    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.expected_px.size() != 0);
    endtask

    // Write one register; the caller drops the enable after the last write
    task automatic write_cfg(input logic [mep_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        tracker.set_reg(idx, data);
    endtask

    initial begin
        int          p;
        int          n_items;
        int          sent;
        logic [9:0]  iter;
        logic [31:0] sre, sim, cre, cim;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default view: image corners, centre point, in-set and early-escape points,
        // coordinates beyond the image
        set_idling(3);
        send_xy(0, 0);
        send_xy(899, 799);
        send_xy(0, 799);
        send_xy(899, 0);
        send_xy(450, 400);
        send_xy(1023, 1023);
        send_xy(1023, 0);
        send_xy(0, 1023);
        send_xy(512, 512);
        send_xy(300, 400);
        send_xy(150, 400);
        send_xy(750, 400);
        send_xy(600, 400);
        send_xy(450, 700);
        send_xy(512, 300);
        send_xy(341, 682);
        wait_drained();

        // No rounds at all; writes to unused indexes must change nothing
        write_cfg(mep_pkg::CFG_MAX_ITER, 32'h0);
        write_cfg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_cfg(CFG_SPARE_HI, 32'h1234_5678);
        cfg_we <= 1'b0;
        send_xy(450, 400);
        send_xy(0, 0);
        wait_drained();

        // Deepest round count on points inside the set
        write_cfg(mep_pkg::CFG_MAX_ITER, 32'hFFFF_FFFF);
        cfg_we <= 1'b0;
        send_xy(450, 400);
        send_xy(300, 400);
        wait_drained();

        // Random views, mostly near the set, with saturating extremes up front
        p = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            set_idling(p % 4);
            n_items = 48;
            sre  = $urandom_range(200, 2000000) | ($urandom & 32'h8000_0000);
            sim  = $urandom_range(200, 2000000) | ($urandom & 32'h8000_0000);
            cre  = int'($urandom_range(0, 671088640)) - 536870912;
            cim  = int'($urandom_range(0, 644245094)) - 322122547;
            iter = 10'($urandom_range(1, 60));
            case (p)
                0: begin
                    sre  = '1;
                    sim  = '1;
                    cre  = 32'h7FFF_FFFF;
                    cim  = 32'h7FFF_FFFF;
                    iter = 10'd1023;
                end
                1: begin
                    sre  = '0;
                    sim  = '0;
                    cre  = 32'h8000_0000;
                    cim  = 32'h8000_0000;
                    iter = 10'd1;
                end
                2: begin
                    iter    = 10'd1023;
                    n_items = 4;
                end
                default: begin
                    if (p % 4 == 3) begin
                        iter    = 10'($urandom_range(100, 300));
                        n_items = 12;
                    end
                end
            endcase
            write_cfg(mep_pkg::CFG_STEP_RE, sre);
            write_cfg(mep_pkg::CFG_STEP_IM, sim);
            write_cfg(mep_pkg::CFG_CENTER_RE, cre);
            write_cfg(mep_pkg::CFG_CENTER_IM, cim);
            write_cfg(mep_pkg::CFG_MAX_ITER, ($urandom & 32'hFFFF_FC00) | 32'(iter));
            cfg_we <= 1'b0;
            // Back-pressure phase: receiver holds off while pixels keep coming
            if (p == HOLD_PHASE) begin
                hold_req = ~hold_req;
            end
            repeat (n_items) begin
                if ($urandom_range(99) < 85) begin
                    send_xy($urandom_range(mep_pkg::IMG_WIDTH_DEF - 1),
                            $urandom_range(mep_pkg::IMG_HEIGHT_DEF - 1));
                end else begin
                    send_xy($urandom_range(1023), $urandom_range(1023));
                end
                sent++;
            end
            wait_drained();
            p++;
        end

        // Allow for any stray result before the verdict
        repeat (2 * int'(tracker.max_iter) + 16) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_px.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
